// ===== hdl/shuffled_lcg_random_generator_defines.svh =====
// ----------------------------------------------------------------------------
// Shuffled LCG random generator - assertion macros
// Concurrent checks used by the top level; empty when SYNTHESIS is set.
// ----------------------------------------------------------------------------
`ifndef SHUFFLED_LCG_RANDOM_GENERATOR_DEFINES_SVH
`define SHUFFLED_LCG_RANDOM_GENERATOR_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, clocked on clk, off during rst
`define SLCG_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("slcg check failed");

// Next-cycle implication, clocked on clk, off during rst
`define SLCG_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("slcg check failed");

`else

`define SLCG_ASSERT_NOW(label, ante, cons)
`define SLCG_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ===== hdl/slcg_pkg.sv =====
// ----------------------------------------------------------------------------
// slcg_pkg
// Widths and constants of the minimal-standard generator and its shuffle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package slcg_pkg;

  // generator value width and modulus 2^31-1
  localparam int VAL_W = 31;
  localparam logic [VAL_W-1:0] LCG_MOD = 31'h7FFF_FFFF;

  // multiplier 16807 fits in 15 bits
  localparam int MUL_W = 15;
  localparam logic [MUL_W-1:0] LCG_MUL = 15'd16807;

  // full product width
  localparam int PROD_W = VAL_W + MUL_W;

  // warm-up steps run beyond the table fill
  localparam int WARMUP_EXTRA = 8;

endpackage

`default_nettype wire

// ===== hdl/slcg_mulmod.sv =====
// ----------------------------------------------------------------------------
// slcg_mulmod
// One generator step x*16807 mod 2^31-1: product registered on start,
// Mersenne fold (high part plus low part, one conditional subtract) after it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module slcg_mulmod
  import slcg_pkg::*;
(
  input  logic             clk,
  input  logic             start,
  input  logic [VAL_W-1:0] x,
  output logic [VAL_W-1:0] result
);

  logic [PROD_W-1:0] prod;
  logic [VAL_W:0]    sum;

  // multiply stage
  always_ff @(posedge clk) begin
    if (start) begin
      prod <= PROD_W'(x) * PROD_W'(LCG_MUL);
    end
  end

  // fold: 2^31 == 1 mod M, so hi + lo, then one subtract
  always_comb begin
    sum = {1'b0, prod[VAL_W-1:0]} + (VAL_W+1)'(prod[PROD_W-1:VAL_W]);
    if (sum >= {1'b0, LCG_MOD}) begin
      result = VAL_W'(sum - {1'b0, LCG_MOD});
    end else begin
      result = sum[VAL_W-1:0];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/slcg_index.sv =====
// ----------------------------------------------------------------------------
// slcg_index
// Shuffle slot from the previous output: x / (1 + (2^31-2)/depth), done as
// compares against constant slot boundaries, result registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module slcg_index
  import slcg_pkg::*;
#(
  parameter int TABLE_DEPTH = 32
)
(
  input  logic                           clk,
  input  logic [VAL_W-1:0]               x,
  output logic [$clog2(TABLE_DEPTH)-1:0] idx
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam logic [VAL_W:0] SPAN = (VAL_W+1)'(1 + (2147483646 / TABLE_DEPTH));

  logic [IDX_W-1:0] q;

  // highest boundary not above x
  always_comb begin
    q = '0;
    for (int k = 1; k < TABLE_DEPTH; k++) begin
      if ({1'b0, x} >= SPAN * (VAL_W+1)'(k)) begin
        q = IDX_W'(k);
      end
    end
  end

  always_ff @(posedge clk) begin
    idx <= q;
  end

endmodule

`default_nettype wire

// ===== hdl/slcg_table_ram.sv =====
// ----------------------------------------------------------------------------
// slcg_table_ram
// Shuffle table: simple dual-port synchronous RAM, one write and one
// registered read per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module slcg_table_ram #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 31
)
(
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/shuffled_lcg_random_generator.sv =====
// ----------------------------------------------------------------------------
// shuffled_lcg_random_generator
// Minimal-standard multiplicative generator feeding a shuffle table held in
// a synchronous RAM; one 31-bit sample per request transaction.
// ----------------------------------------------------------------------------
//
//  channel   handshake               payload
//  ------    ---------------------   -------------------
//  config    cfg_valid / cfg_ready   seed [30:0]
//  request   in_valid / in_stall     reseed
//  result    out_valid / out_stall   sample [30:0]
//
//  A draw runs a RAM read plus multiply, then the fold and table write-back.
//  Seeding first runs TABLE_DEPTH+8 warm-up steps, each a multiply and then
//  a fold in the shared multiply/fold unit, before the draw.
//  Reset is synchronous; the block seeds itself on the first request.
//  The result register lets the next request in while a sample waits.
//
`timescale 1ns / 1ps
`default_nettype none

`include "shuffled_lcg_random_generator_defines.svh"

module shuffled_lcg_random_generator
  import slcg_pkg::*;
#(
  parameter int TABLE_DEPTH = 32
)
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [VAL_W-1:0] seed,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             reseed,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [VAL_W-1:0] sample
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int STEPS = TABLE_DEPTH + WARMUP_EXTRA;
  localparam int CNT_W = $clog2(STEPS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEED_MUL,
    S_SEED_FOLD,
    S_SEED_IDX,
    S_DRAW_RD,
    S_DRAW_WB,
    S_DELIVER
  } state_t;

  state_t           state;
  logic [VAL_W-1:0] seed_reg;
  logic             seeded;
  logic [VAL_W-1:0] lcg_value;
  logic [VAL_W-1:0] last_output;
  logic [CNT_W-1:0] step_cnt;

  logic             mul_start;
  logic [VAL_W-1:0] mul_result;
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic             ram_re;
  logic [VAL_W-1:0] ram_rdata;
  logic [IDX_W-1:0] idx;
  logic [VAL_W-1:0] seed_init;
  logic             out_free;
  logic             out_load;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign out_free  = !out_valid || !out_stall;
  assign out_load  = out_free && (state == S_DRAW_WB || state == S_DELIVER);

  // zero and the modulus itself would lock the generator
  assign seed_init = (seed_reg == '0 || seed_reg == LCG_MOD) ? VAL_W'(1) : seed_reg;

  // step unit, RAM and slot control
  assign mul_start = (state == S_SEED_MUL) || (state == S_DRAW_RD);
  assign ram_re    = (state == S_DRAW_RD);
  assign ram_we    = (state == S_DRAW_WB) ||
                     (state == S_SEED_FOLD && step_cnt < CNT_W'(TABLE_DEPTH));
  assign ram_waddr = (state == S_DRAW_WB) ? idx : step_cnt[IDX_W-1:0];

  slcg_mulmod u_mulmod (
    .clk    (clk),
    .start  (mul_start),
    .x      (lcg_value),
    .result (mul_result)
  );

  slcg_table_ram #(
    .DEPTH (TABLE_DEPTH),
    .WIDTH (VAL_W)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (mul_result),
    .re    (ram_re),
    .raddr (idx),
    .rdata (ram_rdata)
  );

  // slot from last_output, registered in slcg_index
  slcg_index #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_index (
    .clk (clk),
    .x   (last_output),
    .idx (idx)
  );

  // sequencer: seeding, draw, result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      seed_reg  <= VAL_W'(1);
      seeded    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        seed_reg <= seed;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            if (reseed || !seeded) begin
              lcg_value <= seed_init;
              step_cnt  <= CNT_W'(STEPS - 1);
              state     <= S_SEED_MUL;
            end else begin
              state <= S_DRAW_RD;
            end
          end
        end
        S_SEED_MUL: begin
          state <= S_SEED_FOLD;
        end
        S_SEED_FOLD: begin
          lcg_value <= mul_result;
          if (step_cnt == '0) begin
            // slot 0 is filled last and becomes the previous output
            last_output <= mul_result;
            seeded      <= 1'b1;
            state       <= S_SEED_IDX;
          end else begin
            step_cnt <= step_cnt - CNT_W'(1);
            state    <= S_SEED_MUL;
          end
        end
        S_SEED_IDX: begin
          state <= S_DRAW_RD;
        end
        S_DRAW_RD: begin
          state <= S_DRAW_WB;
        end
        S_DRAW_WB: begin
          lcg_value   <= mul_result;
          last_output <= ram_rdata;
          if (out_free) begin
            sample <= ram_rdata;
            state  <= S_IDLE;
          end else begin
            state <= S_DELIVER;
          end
        end
        S_DELIVER: begin
          if (out_free) begin
            sample <= last_output;
            state  <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // checks
  `SLCG_ASSERT_NOW(a_no_rw_overlap, ram_we, !ram_re)
  `SLCG_ASSERT_NOW(a_sample_nonzero, out_valid, sample != '0)
  `SLCG_ASSERT_NOW(a_state_nonzero, seeded, lcg_value != '0)
  `SLCG_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)

endmodule

`default_nettype wire

// ===== tb/tb_shuffled_lcg_random_generator.sv =====
// ----------------------------------------------------------------------------
// tb_shuffled_lcg_random_generator
// Self-checking bench for the shuffled minimal-standard random generator.
// Requests go in with random reseed flags and seed register settings. A
// behavioral copy of the generator and its shuffle table predicts each
// sample, and the monitor compares every result in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_shuffled_lcg_random_generator;
  import slcg_pkg::*;

  localparam int DEPTH = 32;
  localparam int SLOT_W = $clog2(DEPTH);
  localparam longint unsigned MODULUS = LCG_MOD;
  localparam longint unsigned PICK_DIV = 1 + (MODULUS - 1) / DEPTH;
  localparam int RAND_CHUNKS = 4;
  localparam int CHUNK_ITEMS = 108;

  // clock and reset
  logic clk = 1'b0;
  logic rst = 1'b1;

  // DUT ports
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [VAL_W-1:0] seed = '0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic             reseed = 1'b0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [VAL_W-1:0] sample;

  // stimulus control
  bit     request_q[$];
  int     send_idle_pct = 0;
  int     recv_stall_pct = 0;

  // predictor state
  logic [VAL_W-1:0] seed_reg;
  logic [VAL_W-1:0] gen_value;
  logic [VAL_W-1:0] prev_sample;
  logic [VAL_W-1:0] shuffle_tbl [DEPTH];
  logic [VAL_W-1:0] sample_q[$];

  // bookkeeping
  int errors = 0;
  int n_requests = 0;
  int n_reseeds = 0;
  int n_samples = 0;
  int n_seed_writes = 0;

  shuffled_lcg_random_generator #(
    .TABLE_DEPTH (DEPTH)
  ) u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .seed      (seed),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .reseed    (reseed),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sample    (sample)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // one generator step: x * 16807 mod 2^31-1
  function automatic logic [VAL_W-1:0] lcg_advance(logic [VAL_W-1:0] x);
    longint unsigned prod;
    prod = longint'(x) * longint'(LCG_MUL);
    return VAL_W'(prod % MODULUS);
  endfunction

  // seeding: warm-up run, last DEPTH values fill the table, entry 0 last
  function automatic void seed_generator();
    logic [VAL_W-1:0] x;
    x = seed_reg;
    if (x == '0 || x == LCG_MOD)
      x = VAL_W'(1);
    for (int j = DEPTH + WARMUP_EXTRA - 1; j >= 0; j--) begin
      x = lcg_advance(x);
      if (j < DEPTH)
        shuffle_tbl[SLOT_W'(j)] = x;
    end
    gen_value = x;
    prev_sample = shuffle_tbl[0];
  endfunction

  // predicted sample of one request
  function automatic logic [VAL_W-1:0] draw_sample(bit force_seed);
    longint unsigned idx;
    logic [SLOT_W-1:0] slot;
    logic [VAL_W-1:0] pick;
    if (force_seed || prev_sample == '0)
      seed_generator();
    gen_value = lcg_advance(gen_value);
    idx = longint'(prev_sample) / PICK_DIV;
    if (idx >= DEPTH)
      idx = DEPTH - 1;
    slot = SLOT_W'(idx);
    pick = shuffle_tbl[slot];
    shuffle_tbl[slot] = gen_value;
    prev_sample = pick;
    return pick;
  endfunction

  // request driver: holds payload while stalled
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      reseed <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (request_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        reseed <= request_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result back-pressure
  always @(posedge clk) begin
    if (rst)
      out_stall <= 1'b0;
    else
      out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // monitor: config tracking, prediction and result check
  always @(posedge clk) begin
    logic [VAL_W-1:0] want;
    if (rst) begin
      seed_reg = VAL_W'(1);
      gen_value = '0;
      prev_sample = '0;
      for (int i = 0; i < DEPTH; i++)
        shuffle_tbl[SLOT_W'(i)] = '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        seed_reg = seed;
        n_seed_writes++;
      end
      if (out_valid && !out_stall) begin
        n_samples++;
        if (sample_q.size() == 0) begin
          $error("unexpected sample transaction: sample=%0d", sample);
          errors++;
        end else begin
          want = sample_q.pop_front();
          if (sample !== want) begin
            $error("sample mismatch: expected %0d, actual %0d", want, sample);
            errors++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        n_requests++;
        if (reseed)
          n_reseeds++;
        sample_q.push_back(draw_sample(reseed));
      end
    end
  end

  // seed register write, only while idle
  task automatic write_seed(logic [VAL_W-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    seed <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // wait until every request is out and every sample is back
  task automatic drain();
    do @(negedge clk);
    while (request_q.size() != 0 || in_valid || sample_q.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_idling(int send_pct, int recv_pct);
    @(negedge clk);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  // random chunk: mostly plain draws, first one usually reseeds
  task automatic load_random_chunk();
    @(negedge clk);
    request_q.push_back($urandom_range(99) < 70);
    for (int i = 1; i < CHUNK_ITEMS; i++)
      request_q.push_back($urandom_range(99) < 3);
  endtask

  task automatic load_items(bit a, bit b, bit c);
    @(negedge clk);
    request_q.push_back(a);
    request_q.push_back(b);
    request_q.push_back(c);
  endtask

  // main sequence
  initial begin
    logic [VAL_W-1:0] seed_val;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed: first request seeds itself with the reset seed
    set_idling(36, 87);
    load_items(1'b0, 1'b0, 1'b0);
    drain();
    // zero seed behaves as one; rewritten seed waits for a reseed
    write_seed('0);
    load_items(1'b0, 1'b1, 1'b0);
    drain();
    // seed equal to the modulus also behaves as one
    write_seed(LCG_MOD);
    load_items(1'b1, 1'b0, 1'b1);
    drain();
    // largest legal seed, back-to-back reseeds
    write_seed(LCG_MOD - VAL_W'(1));
    load_items(1'b1, 1'b1, 1'b0);
    drain();
    write_seed(31'h2AAA_AAAA);
    write_seed(31'h5555_5555);
    load_items(1'b0, 1'b1, 1'b0);
    drain();

    // random phases with three idling profiles
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: set_idling(36, 87);
        1: set_idling(87, 36);
        default: set_idling(0, 0);
      endcase
      for (int c = 0; c < RAND_CHUNKS; c++) begin
        case ($urandom_range(5))
          0: seed_val = '0;
          1: seed_val = LCG_MOD;
          2: seed_val = LCG_MOD - VAL_W'(1);
          3: seed_val = VAL_W'(1);
          default: seed_val = VAL_W'($urandom);
        endcase
        write_seed(seed_val);
        load_random_chunk();
        drain();
      end
    end

    // catch any late or extra samples
    repeat (120) @(posedge clk);
    if (sample_q.size() != 0) begin
      $error("%0d expected samples never arrived", sample_q.size());
      errors++;
    end

    $display("Covered %0d requests (%0d reseeds), %0d samples checked, %0d seed writes.",
             n_requests, n_reseeds, n_samples, n_seed_writes);
    $display("Idling profiles: sender 36/receiver 87, sender 87/receiver 36, none.");
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // global timeout
  initial begin
    #10_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
